// ----- design/hfpt_pkg.sv -----
// Shared types and constants for the hashed frequency protect table.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package hfpt_pkg;

  // Field widths.
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned THR_W   = 9;

  // Table geometry and hash.
  localparam int unsigned TABLE_SLOTS_DEF = 16384;
  localparam int unsigned HASH_SHIFT_LO   = 6;
  localparam int unsigned HASH_SHIFT_HI   = 18;

  // Counter and threshold constants.
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 8'hFF;
  localparam logic [THR_W-1:0]   THRESHOLD_RESET = 9'd3;

  // Configuration port geometry and register index.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic        REG_PROTECT_THRESHOLD = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;  // Zero one table entry during the clearing pass.
    logic lookup;    // Accept a transaction and read its counter.
    logic update;    // Write back the counter and register the result.
  } hfpt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // The clearing pass is at its last entry.
  } hfpt_sts_t;

endpackage

// ----- design/hfpt_ctrl.sv -----
// Controller state machine for the hashed frequency protect table.
// Sequences the clearing pass after reset and the read then write-back update.
// Depends on hfpt_pkg.
module hfpt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  hfpt_pkg::hfpt_sts_t sts,
  output hfpt_pkg::hfpt_cmd_t cmd,
  output logic              busy
);
  import hfpt_pkg::*;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // State register; reset restarts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Command decode.
  always_comb begin
    cmd.clr_step = (state_r == ST_CLEAR);
    cmd.lookup   = (state_r == ST_IDLE) && start;
    cmd.update   = (state_r == ST_UPDATE);
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ----- design/hfpt_datapath.sv -----
// Datapath for the hashed frequency protect table: hash, counter memory,
// saturating increment, threshold compare and result register.
// Depends on hfpt_pkg.
module hfpt_datapath #(
  parameter int unsigned TABLE_SLOTS = hfpt_pkg::TABLE_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hfpt_pkg::hfpt_cmd_t          cmd,
  output hfpt_pkg::hfpt_sts_t          sts,
  input  logic [hfpt_pkg::ADDR_W-1:0]  in_chunk_address,
  input  logic [hfpt_pkg::THR_W-1:0]   threshold,
  output logic                         out_valid,
  output logic                         out_protect_chunk,
  output logic [hfpt_pkg::COUNT_W-1:0] out_count_after
);
  import hfpt_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_SLOTS);
  localparam logic [IDX_W-1:0] SLOT_MASK = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SLOTS - 1);

  logic [COUNT_W-1:0] mem [TABLE_SLOTS];

  logic [ADDR_W-1:0]  hash;
  logic [IDX_W-1:0]   slot;
  logic [IDX_W-1:0]   slot_r;
  logic [COUNT_W-1:0] rdata_r;
  logic [IDX_W-1:0]   clr_idx_r;
  logic [COUNT_W:0]   inc;
  logic [COUNT_W-1:0] count_nxt;
  logic               protect;
  logic               out_valid_r;
  logic               out_protect_r;
  logic [COUNT_W-1:0] out_count_r;

  // Hash of the incoming address, masked to the table size.
  assign hash = (in_chunk_address >> HASH_SHIFT_LO) ^ (in_chunk_address >> HASH_SHIFT_HI);
  assign slot = hash[IDX_W-1:0] & SLOT_MASK;

  // Saturating increment and threshold compare on the old value plus one.
  assign inc       = {1'b0, rdata_r} + {{COUNT_W{1'b0}}, 1'b1};
  assign count_nxt = (rdata_r == COUNT_MAX) ? rdata_r : inc[COUNT_W-1:0];
  assign protect   = (inc >= threshold);

  // Counter memory: one write port for clearing and updates, one read.
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_idx_r] <= '0;
    end else if (cmd.update) begin
      mem[slot_r] <= count_nxt;
    end
    if (cmd.lookup) begin
      rdata_r <= mem[slot];
      slot_r  <= slot;
    end
  end

  // Clearing pass address counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clr_step) begin
      clr_idx_r <= clr_idx_r + IDX_W'(1);
    end
  end

  assign sts.clr_last = (clr_idx_r == LAST_SLOT);

  // Result register: strobe for one cycle after each update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_protect_r <= protect;
      out_count_r   <= count_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_protect_chunk = out_protect_r;
  assign out_count_after   = out_count_r;

endmodule

// ----- design/hashed_frequency_protect_table.sv -----
// Top level of the hashed frequency protect table: configuration register
// and the controller and datapath. Depends on hfpt_pkg, hfpt_ctrl and
// hfpt_datapath.
//
// Channel        | Ports                                  | Handshake
// input          | start, busy, in_chunk_address          | start && !busy
// result         | out_valid, out_protect_chunk,          | out_valid, one cycle
//                | out_count_after                        |
// configuration  | psel, penable, pwrite, paddr, pwdata,  | APB, pready always high
//                | prdata, pready                         |
//
// Each transaction reads the counter at the accepting edge and writes the
// updated count back in the following update state; the controller's read
// then write-back sequence sets this.
// The result is registered at the write back, and the next transaction may be
// accepted in the cycle in which the result is shown. After reset a clearing
// pass zeroes all TABLE_SLOTS entries (16384 by default), one entry a cycle,
// with busy high. The receiver cannot stall, so results are never held.
module hashed_frequency_protect_table #(
  parameter int unsigned TABLE_SLOTS = hfpt_pkg::TABLE_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [hfpt_pkg::ADDR_W-1:0]     in_chunk_address,
  output logic                            out_valid,
  output logic                            out_protect_chunk,
  output logic [hfpt_pkg::COUNT_W-1:0]    out_count_after,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hfpt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import hfpt_pkg::*;

  hfpt_cmd_t        cmd;
  hfpt_sts_t        sts;
  logic [THR_W-1:0] cfg_threshold_r;
  logic             cfg_wr;
  logic             cfg_sel_thr;

  // Configuration register write, decoded by word address.
  assign pready      = 1'b1;
  assign cfg_sel_thr = (paddr[2] == REG_PROTECT_THRESHOLD);
  assign cfg_wr      = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_threshold_r <= THRESHOLD_RESET;
    end else if (cfg_wr && cfg_sel_thr) begin
      cfg_threshold_r <= pwdata[THR_W-1:0];
    end
  end

  // Read back of the configuration register.
  assign prdata = cfg_sel_thr ? {{(32 - THR_W){1'b0}}, cfg_threshold_r} : 32'h0;

  hfpt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  hfpt_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_chunk_address  (in_chunk_address),
    .threshold         (cfg_threshold_r),
    .out_valid         (out_valid),
    .out_protect_chunk (out_protect_chunk),
    .out_count_after   (out_count_after)
  );

endmodule

// ----- design/hfpt_checker.sv -----
// Port-level checker for the hashed frequency protect table, with its bind.
// Depends on hfpt_pkg and the top level hashed_frequency_protect_table.
module hfpt_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic [hfpt_pkg::COUNT_W-1:0] out_count_after
);
  import hfpt_pkg::*;

  // An accepted transaction makes the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted transaction");

  // Every accepted transaction yields its result once the update state has passed.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("result missing two cycles after acceptance");

  // Results never come in consecutive cycles.
  a_no_double_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe high in two consecutive cycles");

  // A counter after increment is never zero, and a result finds the block idle.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count_after != '0) && !busy)
    else $error("result with zero count or while busy");

endmodule

bind hashed_frequency_protect_table hfpt_checker u_hfpt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_count_after (out_count_after)
);

// ----- tb/tb_hashed_frequency_protect_table.sv -----
// Self-checking testbench for the hashed frequency protect table.
// Holds a scoreboard class with its own counter table and threshold register.
// Depends on hfpt_pkg and hashed_frequency_protect_table.
`timescale 1ns / 100ps

localparam int unsigned PROTECT_TABLE_SLOTS = hfpt_pkg::TABLE_SLOTS_DEF;
localparam int unsigned PROTECT_SLOT_BITS   = $clog2(PROTECT_TABLE_SLOTS);

// Tracks the activation counters and holds the results still to come.
class activation_count_model;
  typedef struct packed {
    logic                         protect;
    logic [hfpt_pkg::COUNT_W-1:0] count;
  } activation_result_t;

  logic [hfpt_pkg::COUNT_W-1:0] slot_counts [PROTECT_TABLE_SLOTS];
  logic [hfpt_pkg::THR_W-1:0]   threshold;
  activation_result_t           pending_results [$];
  int                           errors;

  function new();
    foreach (slot_counts[i]) slot_counts[i] = '0;
    threshold = hfpt_pkg::THRESHOLD_RESET;
    errors    = 0;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  function void set_threshold(logic [31:0] data);
    threshold = data[hfpt_pkg::THR_W-1:0];
  endfunction

  // Slot select: the address folded onto itself, masked to the table size.
  function int unsigned hash_slot(logic [hfpt_pkg::ADDR_W-1:0] addr);
    logic [hfpt_pkg::ADDR_W-1:0] mixed;
    mixed = (addr >> hfpt_pkg::HASH_SHIFT_LO) ^ (addr >> hfpt_pkg::HASH_SHIFT_HI);
    return (mixed[31:0] & (PROTECT_TABLE_SLOTS - 1)) % PROTECT_TABLE_SLOTS;
  endfunction

  // Saturating increment; the compare uses the old count plus one, up to 256.
  function void note_activation(logic [hfpt_pkg::ADDR_W-1:0] addr);
    int unsigned                  slot;
    logic [hfpt_pkg::COUNT_W-1:0] old_count;
    logic [hfpt_pkg::THR_W-1:0]   bumped;
    activation_result_t           res;
    slot        = hash_slot(addr);
    old_count   = slot_counts[slot];
    bumped      = {1'b0, old_count} + 1'b1;
    res.count   = (old_count == hfpt_pkg::COUNT_MAX) ? old_count
                                                     : bumped[hfpt_pkg::COUNT_W-1:0];
    res.protect = (bumped >= threshold);
    slot_counts[slot] = res.count;
    pending_results.push_back(res);
  endfunction

  function void check_result(logic protect, logic [hfpt_pkg::COUNT_W-1:0] count);
    activation_result_t exp;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result: protect_chunk %0d, count_after %0d",
               $time, protect, count);
      errors++;
      return;
    end
    exp = pending_results.pop_front();
    if (protect !== exp.protect) begin
      $display("%0t: protect_chunk mismatch: expected %0d, actual %0d",
               $time, exp.protect, protect);
      errors++;
    end
    if (count !== exp.count) begin
      $display("%0t: count_after mismatch: expected %0d, actual %0d",
               $time, exp.count, count);
      errors++;
    end
  endfunction

  function void check_threshold_read(logic [31:0] data);
    logic [31:0] exp;
    exp = 32'(threshold);
    if (data !== exp) begin
      $display("%0t: protect_threshold read mismatch: expected %0d, actual %0d",
               $time, exp, data);
      errors++;
    end
  endfunction
endclass

module tb_hashed_frequency_protect_table;
  localparam int unsigned WATCHDOG_LIMIT = 50000;
  localparam int unsigned PHASE_ITEMS    = 56;
  localparam int unsigned PHASE_COUNT    = 9;
  localparam logic [hfpt_pkg::CFG_ADDR_W-1:0] THRESHOLD_ADDR =
    hfpt_pkg::CFG_ADDR_W'(4 * int'(hfpt_pkg::REG_PROTECT_THRESHOLD));
  localparam logic [hfpt_pkg::CFG_ADDR_W-1:0] UNMAPPED_REG_ADDR = THRESHOLD_ADDR + 3'd4;

  logic                            clk               = 1'b0;
  logic                            rst_n             = 1'b0;
  logic                            start             = 1'b0;
  logic                            busy;
  logic [hfpt_pkg::ADDR_W-1:0]     in_chunk_address  = '0;
  logic                            out_valid;
  logic                            out_protect_chunk;
  logic [hfpt_pkg::COUNT_W-1:0]    out_count_after;
  logic                            psel              = 1'b0;
  logic                            penable           = 1'b0;
  logic                            pwrite            = 1'b0;
  logic [hfpt_pkg::CFG_ADDR_W-1:0] paddr             = '0;
  logic [31:0]                     pwdata            = '0;
  logic [31:0]                     prdata;
  logic                            pready;

  activation_count_model tracker = new();
  int unsigned           quiet_cycles = 0;

  hashed_frequency_protect_table dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_chunk_address  (in_chunk_address),
    .out_valid         (out_valid),
    .out_protect_chunk (out_protect_chunk),
    .out_count_after   (out_count_after),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #5 clk = ~clk;

  // Every result is taken in the cycle it is shown.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      tracker.check_result(out_protect_chunk, out_count_after);
    end
  end

  // Watchdog: ends the run after too long without any transaction.
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1 || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Random address whose hash lands on the given slot. Bits are fixed from
  // the top down so that the overlapping address bits are settled first.
  function automatic logic [hfpt_pkg::ADDR_W-1:0] addr_for_slot(int unsigned slot);
    logic [hfpt_pkg::ADDR_W-1:0] addr;
    addr = {$urandom, $urandom};
    for (int k = PROTECT_SLOT_BITS - 1; k >= 0; k--) begin
      addr[hfpt_pkg::HASH_SHIFT_LO + k] = slot[k] ^ addr[hfpt_pkg::HASH_SHIFT_HI + k];
    end
    return addr;
  endfunction

  // One activation transaction, after a random idle gap.
  task automatic drive_activation(input logic [hfpt_pkg::ADDR_W-1:0] addr,
                                  input int unsigned idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start            <= 1'b0;
      in_chunk_address <= {$urandom, $urandom};
      @(posedge clk);
    end
    start            <= 1'b1;
    in_chunk_address <= addr;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.note_activation(addr);
  endtask

  // One register transaction, issued only once the block has drained.
  task automatic cfg_transfer(input logic is_write,
                              input logic [hfpt_pkg::CFG_ADDR_W-1:0] addr,
                              input logic [31:0] data);
    start <= 1'b0;
    while (tracker.pending() != 0 || busy !== 1'b0) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (is_write && addr == THRESHOLD_ADDR) begin
      tracker.set_threshold(data);
    end else if (!is_write) begin
      tracker.check_threshold_read(prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_threshold(input logic [hfpt_pkg::THR_W-1:0] value);
    cfg_transfer(1'b1, THRESHOLD_ADDR, 32'(value));
    cfg_transfer(1'b0, THRESHOLD_ADDR, '0);
  endtask

  initial begin
    int unsigned                hot_slot;
    int unsigned                warm_slots [6];
    int unsigned                idle_pct;
    int unsigned                pick;
    logic [hfpt_pkg::THR_W-1:0] phase_thresholds [PHASE_COUNT];
    logic [hfpt_pkg::ADDR_W-1:0] addr;

    phase_thresholds = '{9'd2, 9'd0, 9'd511, 9'd0, 9'd1, 9'd128, 9'd257, 9'd255, 9'd256};
    phase_thresholds[3] = 9'($urandom_range(0, 511));
    hot_slot = $urandom_range(0, PROTECT_TABLE_SLOTS - 1);
    foreach (warm_slots[i]) warm_slots[i] = $urandom_range(0, PROTECT_TABLE_SLOTS - 1);
    warm_slots[0] = PROTECT_TABLE_SLOTS - 1;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // Let the clearing pass finish.
    do @(posedge clk); while (busy !== 1'b0);

    // Directed part: reset threshold, address extremes, both ends of the table.
    cfg_transfer(1'b0, THRESHOLD_ADDR, '0);
    drive_activation('0, 0);
    drive_activation('1, 0);
    drive_activation(addr_for_slot(0), 0);
    drive_activation(64'h8000_0000_0000_0000, 0);
    drive_activation(addr_for_slot(PROTECT_TABLE_SLOTS - 1), 0);
    drive_activation(64'hAAAA_AAAA_AAAA_AAAA, 0);
    drive_activation(64'h5555_5555_5555_5555, 0);
    drive_activation(64'h0000_0000_0000_003F, 0);

    // Threshold zero protects everything.
    set_threshold(9'd0);
    drive_activation(addr_for_slot(PROTECT_TABLE_SLOTS - 1), 0);
    drive_activation({$urandom, $urandom}, 0);

    // A write to an unmapped address must leave the threshold alone.
    cfg_transfer(1'b1, UNMAPPED_REG_ADDR, 32'd1);
    cfg_transfer(1'b0, THRESHOLD_ADDR, '0);

    // Thresholds above 256 never protect.
    set_threshold(9'd511);
    drive_activation(addr_for_slot(0), 0);
    drive_activation(addr_for_slot(0), 0);
    set_threshold(9'd257);
    drive_activation(addr_for_slot(0), 0);

    set_threshold(9'd1);
    drive_activation({$urandom, $urandom}, 0);
    drive_activation(addr_for_slot(PROTECT_TABLE_SLOTS - 1), 0);
    set_threshold(9'd256);
    drive_activation(addr_for_slot(0), 0);

    // Random part: one hot slot runs into saturation, a few warm slots cross
    // the thresholds, and the rest is scattered addresses.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      set_threshold(phase_thresholds[p]);
      idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 57 : 18);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          addr = addr_for_slot(hot_slot);
        end else if (pick < 90) begin
          addr = addr_for_slot(warm_slots[$urandom_range(0, 5)]);
        end else begin
          addr = {$urandom, $urandom};
        end
        drive_activation(addr, idle_pct);
        // Hold the sender off once until everything in flight has come back.
        if (p == 4 && i == PHASE_ITEMS / 2) begin
          start <= 1'b0;
          while (tracker.pending() != 0) @(posedge clk);
        end
      end
    end

    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
